[hw/rtl/plid_pkg.sv]
package plid_pkg;

    localparam int DATA_W = 32;
    localparam int POS_W  = 8;
    localparam int LEN_W  = 8;

    typedef enum logic [0:0] {
        CMD_INSERT = 1'b0,
        CMD_DELETE = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef struct packed {
        logic                     insert_en;
        logic                     delete_en;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } cell_ctrl_t;

endpackage

[hw/rtl/positional_list_insert_delete_unit.sv]
// Bounded ordered list of signed 32-bit words held in a row of CAPACITY cells.
// Each request inserts a word at a position (0 up to the current length) or
// deletes the word at a position (0 up to length-1); every cell compares its
// own index with the position and shifts, loads or holds in the same cycle,
// so one request is taken every clock unless the output stalls. The result
// (status, removed word, length after the request) is in an output register
// on the cycle after acceptance; while it waits the input is held off, and a
// new request is taken in the cycle that the waiting result is taken. Bad
// requests leave the list unchanged. Reset clears count and valid, not cells.
module positional_list_insert_delete_unit
    import plid_pkg::*;
#(
    parameter int CAPACITY = 128
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [0:0]               s_cmd,
    input  logic [POS_W-1:0]         s_position,
    input  logic signed [DATA_W-1:0] s_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [1:0]               m_status,
    output logic signed [DATA_W-1:0] m_removed_value,
    output logic [LEN_W-1:0]         m_list_length
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = (CW > POS_W) ? CW : POS_W;

    logic [CW-1:0]            count_reg, count_next;
    logic                     out_valid_reg, out_valid_next;
    status_t                  status_reg, status_next;
    logic signed [DATA_W-1:0] removed_reg, removed_next;
    logic [LEN_W-1:0]         length_reg, length_next;

    logic                     accept;
    logic [EW-1:0]            pos_w, cnt_w;
    cell_ctrl_t               ctrl;
    logic signed [DATA_W-1:0] cell_data [CAPACITY];
    logic signed [DATA_W-1:0] cell_sel  [CAPACITY];
    logic signed [DATA_W-1:0] sel_or;

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign pos_w   = EW'(s_position);
    assign cnt_w   = EW'(count_reg);

    always_comb begin
        sel_or = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            sel_or = sel_or | cell_sel[i];
        end
    end

    always_comb begin
        ctrl.insert_en = 1'b0;
        ctrl.delete_en = 1'b0;
        ctrl.position  = s_position;
        ctrl.value     = s_value;
        count_next     = count_reg;
        status_next    = status_reg;
        removed_next   = removed_reg;
        length_next    = length_reg;
        out_valid_next = out_valid_reg && !m_ready;
        if (accept) begin
            out_valid_next = 1'b1;
            removed_next   = '0;
            status_next    = ST_OK;
            if (s_cmd == CMD_INSERT) begin
                if (pos_w > cnt_w) begin
                    status_next = ST_BADPOS;
                end else if (cnt_w == EW'(CAPACITY)) begin
                    status_next = ST_FULL;
                end else begin
                    ctrl.insert_en = 1'b1;
                    count_next     = count_reg + CW'(1);
                end
            end else begin
                if (count_reg == '0) begin
                    status_next = ST_EMPTY;
                end else if (pos_w >= cnt_w) begin
                    status_next = ST_BADPOS;
                end else begin
                    ctrl.delete_en = 1'b1;
                    removed_next   = sel_or;
                    count_next     = count_reg - CW'(1);
                end
            end
            length_next = LEN_W'(count_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg  <= status_next;
        removed_reg <= removed_next;
        length_reg  <= length_next;
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [DATA_W-1:0] prev_d, next_d;
        if (g == 0) begin : g_first
            assign prev_d = '0;
        end else begin : g_mid
            assign prev_d = cell_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign next_d = '0;
        end else begin : g_inner
            assign next_d = cell_data[g+1];
        end
        plid_cell #(
            .INDEX(g)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .prev_data (prev_d),
            .next_data (next_d),
            .data      (cell_data[g]),
            .sel_data  (cell_sel[g])
        );
    end

    assign m_valid         = out_valid_reg;
    assign m_status        = status_reg;
    assign m_removed_value = removed_reg;
    assign m_list_length   = length_reg;

endmodule

[hw/rtl/plid_cell.sv]
module plid_cell
    import plid_pkg::*;
#(
    parameter int INDEX = 0
) (
    input  logic                     aclk,
    input  cell_ctrl_t               ctrl,
    input  logic signed [DATA_W-1:0] prev_data,
    input  logic signed [DATA_W-1:0] next_data,
    output logic signed [DATA_W-1:0] data,
    output logic signed [DATA_W-1:0] sel_data
);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic                     at_pos;
    logic                     after_pos;

    assign at_pos    = (INDEX == int'(ctrl.position));
    assign after_pos = (INDEX > int'(ctrl.position));

    always_comb begin
        data_next = data_reg;
        if (ctrl.insert_en) begin
            if (after_pos) begin
                data_next = prev_data;
            end else if (at_pos) begin
                data_next = ctrl.value;
            end
        end else if (ctrl.delete_en) begin
            if (after_pos || at_pos) begin
                data_next = next_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data     = data_reg;
    assign sel_data = at_pos ? data_reg : '0;

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
module testbench;
    import plid_pkg::*;

    localparam int CAPACITY      = 128;
    localparam int RANDOM_ITEMS  = 2000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 20;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct packed {
        status_t                  status;
        logic signed [DATA_W-1:0] removed;
        logic [LEN_W-1:0]         count_after;
    } list_outcome_t;

    class list_mirror;
        logic signed [DATA_W-1:0] cells [CAPACITY];
        int unsigned              held;
        int unsigned              peak;
        list_outcome_t            pending [$];
        int                       errors;
        int                       n_insert;
        int                       n_delete;
        int                       status_hits [4];

        task report(string what, logic [31:0] want, logic [31:0] got);
            errors++;
            if (errors <= 50)
                $display("[%0t] mismatch on %s: expected %h, got %h", $time, what, want, got);
        endtask

        function void note_request(cmd_t cmd, logic [POS_W-1:0] pos,
                                   logic signed [DATA_W-1:0] val);
            list_outcome_t r;
            int            i;
            r.status  = ST_OK;
            r.removed = '0;
            if (cmd == CMD_INSERT) begin
                n_insert++;
                if (pos > held) begin
                    r.status = ST_BADPOS;
                end else if (held >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    for (i = held; i > pos; i--)
                        cells[i] = cells[i-1];
                    cells[pos] = val;
                    held++;
                end
            end else begin
                n_delete++;
                if (held == 0) begin
                    r.status = ST_EMPTY;
                end else if (pos >= held) begin
                    r.status = ST_BADPOS;
                end else begin
                    r.removed = cells[pos];
                    for (i = pos; i + 1 < held; i++)
                        cells[i] = cells[i+1];
                    held--;
                end
            end
            if (held > peak)
                peak = held;
            r.count_after = LEN_W'(held);
            status_hits[r.status]++;
            pending.push_back(r);
        endfunction

        task check_result(logic [1:0] status, logic signed [DATA_W-1:0] removed,
                          logic [LEN_W-1:0] count_after);
            list_outcome_t want;
            if (pending.size() == 0) begin
                report("unexpected word", '0, {status, removed[29:0]});
            end else begin
                want = pending.pop_front();
                if (status !== want.status)
                    report("status", 32'(want.status), 32'(status));
                if (removed !== want.removed)
                    report("removed_value", want.removed, removed);
                if (count_after !== want.count_after)
                    report("list_length", 32'(want.count_after), 32'(count_after));
            end
        endtask
    endclass

    logic                     aclk;
    logic                     aresetn    = 1'b0;
    logic                     s_valid    = 1'b0;
    logic                     s_ready;
    logic [0:0]               s_cmd      = CMD_INSERT;
    logic [POS_W-1:0]         s_position = '0;
    logic signed [DATA_W-1:0] s_value    = '0;
    logic                     m_valid;
    logic                     m_ready    = 1'b0;
    logic [1:0]               m_status;
    logic signed [DATA_W-1:0] m_removed_value;
    logic [LEN_W-1:0]         m_list_length;

    list_mirror mirror = new();
    bit         hold_req = 1'b0;
    int         burst_left = 0;
    int         sent = 0;
    int         cycle_count = 0;

    positional_list_insert_delete_unit #(.CAPACITY(CAPACITY)) u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_position      (s_position),
        .s_value         (s_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_removed_value (m_removed_value),
        .m_list_length   (m_list_length)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    task automatic send_word(cmd_t cmd, logic [POS_W-1:0] pos, logic signed [DATA_W-1:0] val);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 60);
        end
        burst_left--;
        s_valid    <= 1'b1;
        s_cmd      <= cmd;
        s_position <= pos;
        s_value    <= val;
        do @(posedge aclk); while (!s_ready);
        mirror.note_request(cmd, pos, val);
        sent++;
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        burst_left = 0;
        while (mirror.pending.size() != 0) @(posedge aclk);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return '0;
            3:       return -1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [POS_W-1:0] stray_position(int unsigned held);
        case ($urandom_range(0, 3))
            0:       return POS_W'(held);
            1:       return POS_W'(held + 1);
            2:       return POS_W'($urandom_range(128, 255));
            default: return POS_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_noise();
        cmd_t cmd;
        cmd = cmd_t'($urandom_range(0, 1));
        send_word(cmd, stray_position(mirror.held), pick_value());
    endtask

    task automatic send_insert();
        send_word(CMD_INSERT, POS_W'($urandom_range(0, mirror.held)), pick_value());
    endtask

    task automatic send_delete();
        if (mirror.held == 0)
            send_noise();
        else
            send_word(CMD_DELETE, POS_W'($urandom_range(0, mirror.held - 1)), pick_value());
    endtask

    initial begin
        int ph;
        int mode;
        int span;
        int k;
        int extra;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_word(CMD_DELETE, 8'd0,   32'sh1234_5678);
        send_word(CMD_DELETE, 8'd255, 32'sh0);
        send_word(CMD_INSERT, 8'd1,   32'sh1);
        send_word(CMD_INSERT, 8'd255, 32'sh2);
        send_word(CMD_INSERT, 8'd0,   32'sh7fff_ffff);
        send_word(CMD_INSERT, 8'd1,   32'sh8000_0000);
        send_word(CMD_INSERT, 8'd0,   -1);
        send_word(CMD_INSERT, 8'd1,   32'sh0);
        send_word(CMD_INSERT, 8'd5,   32'sh3);
        send_word(CMD_INSERT, 8'd4,   32'sh5555_5555);
        send_word(CMD_INSERT, 8'd2,   32'shaaaa_aaaa);
        send_word(CMD_DELETE, 8'd5,   32'sh0);
        send_word(CMD_DELETE, 8'd5,   32'sh0);
        send_word(CMD_DELETE, 8'd255, 32'sh0);
        send_word(CMD_DELETE, 8'd0,   32'sh0);
        send_word(CMD_DELETE, 8'd2,   32'sh0);
        send_word(CMD_DELETE, 8'd128, 32'sh0);
        send_word(CMD_INSERT, 8'd128, 32'sh4);
        send_word(CMD_DELETE, 8'd1,   32'sh0);
        send_word(CMD_DELETE, 8'd1,   32'sh0);
        send_word(CMD_DELETE, 8'd0,   32'sh0);
        send_word(CMD_DELETE, 8'd0,   32'sh0);
        wait_for_results();

        sent = 0;
        ph = 0;
        while (sent < RANDOM_ITEMS) begin
            mode = (ph == 0) ? 0 : $urandom_range(0, 2);
            if (ph == 0 || $urandom_range(0, 3) == 0)
                hold_req = 1'b1;
            span = $urandom_range(40, 160);
            extra = $urandom_range(2, 5);
            for (k = 0; k < 400; k++) begin
                if (mode == 0) begin
                    if (mirror.held == CAPACITY) begin
                        if (extra == 0)
                            break;
                        extra--;
                    end
                    if ($urandom_range(0, 9) != 0)
                        send_insert();
                    else
                        send_noise();
                end else if (mode == 1) begin
                    if (mirror.held == 0) begin
                        if (extra == 0)
                            break;
                        extra--;
                    end
                    if ($urandom_range(0, 9) != 0)
                        send_delete();
                    else
                        send_noise();
                end else begin
                    if (k >= span)
                        break;
                    case ($urandom_range(0, 4))
                        0, 1:    send_insert();
                        2, 3:    send_delete();
                        default: send_noise();
                    endcase
                end
            end
            if (ph == 1 || $urandom_range(0, 2) == 0)
                wait_for_results();
            ph++;
        end

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Ran %0d inserts and %0d deletes, peak length %0d of %0d.",
                 mirror.n_insert, mirror.n_delete, mirror.peak, CAPACITY);
        $display("Outcomes: ok %0d, bad position %0d, empty %0d, full %0d; %0d mismatches.",
                 mirror.status_hits[ST_OK], mirror.status_hits[ST_BADPOS],
                 mirror.status_hits[ST_EMPTY], mirror.status_hits[ST_FULL], mirror.errors);
        if (mirror.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        int   mode;
        int   left;
        int   tick;
        logic rdy;
        left = 0;
        tick = 0;
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(64, 256);
            end
            left--;
            tick++;
            case (mode)
                0:       rdy = 1'b1;
                1:       rdy = $urandom_range(0, 1);
                2:       rdy = (tick % 4) != 3;
                default: rdy = $urandom_range(0, 7) != 0;
            endcase
            m_ready <= rdy;
            @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            mirror.check_result(m_status, m_removed_value, m_list_length);
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, mirror.pending.size());
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule

[files.f]
hw/rtl/plid_pkg.sv
hw/rtl/plid_cell.sv
hw/rtl/positional_list_insert_delete_unit.sv
tb/testbench.sv
